@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL files.
// Depends on a clock named clk and an active-high reset named rst in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check an implication in the next cycle, outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/tass_pkg.sv @@
// Types, register indexes and coil phase tables for the two-axis stepper sequencer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tass_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int POS_W      = 16;
  localparam int MOVE_W     = 16;
  localparam int COIL_W     = 4;
  localparam int DELAY_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_REV  = 2'd2;

  localparam logic [POS_W-1:0] STEPS_REV_RESET = 16'd200;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_START = 1'b1
  } cmd_t;

  localparam logic [COIL_W-1:0] FULL_TAB [4] = '{4'd5, 4'd6, 4'd10, 4'd9};
  localparam logic [COIL_W-1:0] HALF_TAB [8] =
    '{4'd5, 4'd4, 4'd6, 4'd2, 4'd10, 4'd8, 4'd9, 4'd1};

  // Coil drive for a position phase in full or half step.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic [2:0] phase,
                                                     input logic       full);
    if (full) begin
      return FULL_TAB[phase[1:0]];
    end
    return HALF_TAB[phase];
  endfunction

endpackage

`default_nettype wire

@@ sv/two_axis_stepper_sequencer.sv @@
// Two-axis stepper sequencer top level: input register, step logic, result register.
// Depends on tass_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// One input transfer yields exactly one result transfer, via the input register and
// then the result register. Unless the output side stalls, a transfer is taken every
// clock: the input register and the result register advance together, and all state
// updates for a tick or a start are one short compare-and-count pass between them, so
// throughput is one item per clock. s_tuser selects tick (0) or start (1); a start
// carries signed x and y step counts in s_tdata. Each result gives both coil patterns,
// the busy flag and the reject flag for a start that came while a move was running.
// Write configuration only while no item is in flight.
`include "assert_macros.svh"

module two_axis_stepper_sequencer
  import tass_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data,
  input  wire                  s_tvalid,
  output logic                 s_tready,
  input  wire [31:0]           s_tdata,   // x_move[15:0], y_move[31:16]
  input  wire                  s_tuser,   // command
  output logic                 m_tvalid,
  input  wire                  m_tready,
  output logic [15:0]          m_tdata    // coils_x[3:0], coils_y[7:4], busy_res[8],
                                          // rejected[9], zero[15:10]
);

  localparam int MAG_W = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam int CMP_W = (COUNT_BITS > DELAY_W) ? COUNT_BITS : DELAY_W;
  localparam logic [MAG_W-1:0] CNT_MAX_M = MAG_W'({COUNT_BITS{1'b1}});

  // configuration
  logic [DELAY_W-1:0] step_delay_ticks;
  logic               full_step_mode;
  logic [POS_W-1:0]   steps_per_rev;

  // input register
  logic               in_valid;
  cmd_t               in_cmd;
  logic [MOVE_W-1:0]  in_x;
  logic [MOVE_W-1:0]  in_y;

  // sequencer state
  logic [POS_W-1:0]      x_position, x_position_next;
  logic [POS_W-1:0]      y_position, y_position_next;
  logic [COUNT_BITS-1:0] x_remaining, x_remaining_next;
  logic [COUNT_BITS-1:0] y_remaining, y_remaining_next;
  logic                  x_forward, x_forward_next;
  logic                  y_forward, y_forward_next;
  logic                  last_was_x, last_was_x_next;
  logic [COUNT_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [COIL_W-1:0]     x_coil_latch, x_coil_latch_next;
  logic [COIL_W-1:0]     y_coil_latch, y_coil_latch_next;
  logic                  rej_next;

  // result register
  logic [COIL_W-1:0]     res_coils_x;
  logic [COIL_W-1:0]     res_coils_y;
  logic                  res_busy;
  logic                  res_rejected;

  logic                  adv;
  logic                  busy;
  logic [16:0]           modulus;
  logic [COUNT_BITS-1:0] elapsed_inc;
  logic                  step_x;
  logic [POS_W-1:0]      x_pos_step;
  logic [POS_W-1:0]      y_pos_step;

  function automatic logic [COUNT_BITS-1:0] magnitude(input logic [MOVE_W-1:0] v);
    logic [16:0]      mag;
    logic [MAG_W-1:0] mag_w;
    mag   = v[MOVE_W-1] ? (17'h10000 - {1'b0, v}) : {1'b0, v};
    mag_w = MAG_W'(mag);
    if (mag_w > CNT_MAX_M) begin
      mag_w = CNT_MAX_M;
    end
    return COUNT_BITS'(mag_w);
  endfunction

  function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] pos,
                                                input logic             fwd,
                                                input logic [16:0]      m);
    logic [16:0] n;
    logic [16:0] r;
    n = {1'b0, pos} + 17'd1;
    if (fwd) begin
      r = (n >= m) ? 17'd0 : n;
    end else if (pos == '0 || {1'b0, pos} >= m) begin
      r = m - 17'd1;
    end else begin
      r = {1'b0, pos} - 17'd1;
    end
    return r[POS_W-1:0];
  endfunction

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  assign busy        = (x_remaining != '0) || (y_remaining != '0);
  assign modulus     = (steps_per_rev == '0) ? 17'h10000 : {1'b0, steps_per_rev};
  assign elapsed_inc = (elapsed_ticks != '1) ? elapsed_ticks + 1'b1 : elapsed_ticks;
  assign step_x      = (x_remaining != '0) && (!last_was_x || y_remaining == '0);
  assign x_pos_step  = pos_step(x_position, x_forward, modulus);
  assign y_pos_step  = pos_step(y_position, y_forward, modulus);

  always_comb begin
    x_position_next    = x_position;
    y_position_next    = y_position;
    x_remaining_next   = x_remaining;
    y_remaining_next   = y_remaining;
    x_forward_next     = x_forward;
    y_forward_next     = y_forward;
    last_was_x_next    = last_was_x;
    elapsed_ticks_next = elapsed_ticks;
    x_coil_latch_next  = x_coil_latch;
    y_coil_latch_next  = y_coil_latch;
    rej_next           = 1'b0;
    if (in_cmd == CMD_START) begin
      if (busy) begin
        rej_next = 1'b1;
      end else begin
        x_remaining_next = magnitude(in_x);
        y_remaining_next = magnitude(in_y);
        if (in_x != '0) begin
          x_forward_next = !in_x[MOVE_W-1];
        end
        if (in_y != '0) begin
          y_forward_next = !in_y[MOVE_W-1];
        end
        last_was_x_next = 1'b0;
      end
    end else begin
      elapsed_ticks_next = elapsed_inc;
      if (busy && CMP_W'(elapsed_inc) >= CMP_W'(step_delay_ticks)) begin
        elapsed_ticks_next = '0;
        if (step_x) begin
          last_was_x_next   = 1'b1;
          x_position_next   = x_pos_step;
          x_remaining_next  = x_remaining - 1'b1;
          x_coil_latch_next = coil_pattern(x_pos_step[2:0], full_step_mode);
        end else begin
          last_was_x_next   = 1'b0;
          y_position_next   = y_pos_step;
          y_remaining_next  = y_remaining - 1'b1;
          y_coil_latch_next = coil_pattern(y_pos_step[2:0], full_step_mode);
        end
        if (x_remaining_next == '0) begin
          x_coil_latch_next = '0;
        end
        if (y_remaining_next == '0) begin
          y_coil_latch_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay_ticks <= '0;
      full_step_mode   <= 1'b1;
      steps_per_rev    <= STEPS_REV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_DELAY: step_delay_ticks <= cfg_data;
        REG_FULL_STEP:  full_step_mode   <= cfg_data[0];
        REG_STEPS_REV:  steps_per_rev    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_cmd <= cmd_t'(s_tuser);
      in_x   <= s_tdata[15:0];
      in_y   <= s_tdata[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_position    <= '0;
      y_position    <= '0;
      x_remaining   <= '0;
      y_remaining   <= '0;
      x_forward     <= 1'b0;
      y_forward     <= 1'b0;
      last_was_x    <= 1'b0;
      elapsed_ticks <= '0;
      x_coil_latch  <= '0;
      y_coil_latch  <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (adv) begin
        x_position    <= x_position_next;
        y_position    <= y_position_next;
        x_remaining   <= x_remaining_next;
        y_remaining   <= y_remaining_next;
        x_forward     <= x_forward_next;
        y_forward     <= y_forward_next;
        last_was_x    <= last_was_x_next;
        elapsed_ticks <= elapsed_ticks_next;
        x_coil_latch  <= x_coil_latch_next;
        y_coil_latch  <= y_coil_latch_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_coils_x  <= x_coil_latch_next;
      res_coils_y  <= y_coil_latch_next;
      res_busy     <= (x_remaining_next != '0) || (y_remaining_next != '0);
      res_rejected <= rej_next;
    end
  end

  assign m_tdata = {6'd0, res_rejected, res_busy, res_coils_y, res_coils_x};

  `ASSERT_CLK(a_rej_busy, !(m_tvalid && res_rejected) || res_busy,
              "rejected result without busy")
  `ASSERT_CLK(a_idle_coils_off, !(m_tvalid && !res_busy) ||
              (res_coils_x == '0 && res_coils_y == '0), "coils on while idle")
  `ASSERT_CLK(a_x_done_off, x_remaining != '0 || x_coil_latch == '0,
              "x coils on with no steps left")
  `ASSERT_CLK(a_y_done_off, y_remaining != '0 || y_coil_latch == '0,
              "y coils on with no steps left")
  `ASSERT_NEXT(a_hold_input, in_valid && !adv, in_valid, "input item dropped while stalled")

endmodule

`default_nettype wire
